FILE: rtl/reno_cw_pkg.sv
// Shared types and constants of the Reno congestion-window engine.
// Used by the controller, the datapath, the divider and the top level.
package reno_cw_pkg;

  // Field widths fixed by the stream format.
  localparam int MSS_W      = 16;
  localparam int ACK_W      = 32;
  localparam int OUT_WIN_W  = 32;
  localparam int PRODUCT_W  = 2 * MSS_W;
  localparam int DIVIDEND_W = PRODUCT_W;

  // Reset values of the protocol state.
  localparam logic [MSS_W-1:0] RESET_MSS       = 16'd1460;
  localparam logic [15:0]      RESET_WINDOW    = 16'd1460;
  localparam logic [15:0]      RESET_THRESHOLD = 16'd65535;

  // Duplicate counter: fast retransmit on the third duplicate, counter stops at four.
  localparam logic [2:0] DUP_FAST = 3'd3;
  localparam logic [2:0] DUP_SAT  = 3'd4;

  // Input kinds carried on the slave tuser bit.
  localparam logic FUNC_ACK     = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // Congestion phase, also reported on the result stream.
  typedef enum logic [1:0] {
    PH_SLOW  = 2'd0,
    PH_AVOID = 2'd1,
    PH_RECOV = 2'd2
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIVIDE,
    ST_COMMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
  } cw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } cw_status_t;

endpackage

FILE: rtl/reno_cw_div.sv
// Radix-2 restoring divider for the congestion-avoidance increment.
// Depends on reno_cw_pkg for the dividend width; one quotient bit per cycle.
module reno_cw_div #(
  parameter int DIVISOR_W = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [reno_cw_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]               divisor,
  output logic                               done,
  output logic [reno_cw_pkg::DIVIDEND_W-1:0] quotient
);

  localparam int QW    = reno_cw_pkg::DIVIDEND_W;
  localparam int CNT_W = $clog2(QW);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DIVISOR_W-1:0] rem;
  logic [QW-1:0]    quo;
  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign trial = {rem, quo[QW-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // The last step completes at the edge where done is high.
  assign done     = busy && (count == CNT_W'(QW - 1));
  assign quotient = quo;

  // Busy flag and step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (busy) begin
      if (fits) begin
        rem <= diff[DIVISOR_W-1:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        quo <= {quo[QW-2:0], 1'b0};
      end
    end
  end

endmodule

FILE: rtl/reno_cw_ctrl.sv
// Controller state machine of the Reno congestion-window engine.
// Depends on reno_cw_pkg for the state, command and status types.
module reno_cw_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  reno_cw_pkg::cw_status_t status,
  output reno_cw_pkg::cw_cmd_t    cmd
);

  reno_cw_pkg::ctrl_state_t state;
  reno_cw_pkg::ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= reno_cw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state)
      reno_cw_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = reno_cw_pkg::ST_EVAL;
        end
      end
      reno_cw_pkg::ST_EVAL: begin
        if (status.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = reno_cw_pkg::ST_DIVIDE;
        end else begin
          state_next = reno_cw_pkg::ST_COMMIT;
        end
      end
      reno_cw_pkg::ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = reno_cw_pkg::ST_COMMIT;
        end
      end
      reno_cw_pkg::ST_COMMIT: begin
        // Update the state only once the result register can take the result.
        cmd.commit = status.out_free;
        if (status.out_free) begin
          state_next = reno_cw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = reno_cw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/reno_cw_dp.sv
// Datapath of the Reno congestion-window engine: protocol state, segment-size
// register, decision logic, saturating adder and result register.
// Depends on reno_cw_pkg and instantiates reno_cw_div.
module reno_cw_dp #(
  parameter int WINDOW_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [reno_cw_pkg::MSS_W-1:0]   cfg_wr_data,
  input  logic [reno_cw_pkg::ACK_W-1:0]   in_ack,
  input  logic                            in_func,
  input  reno_cw_pkg::cw_cmd_t            cmd,
  output reno_cw_pkg::cw_status_t         status,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_retransmit,
  output logic [reno_cw_pkg::OUT_WIN_W-1:0] out_window,
  output reno_cw_pkg::phase_t             out_phase
);

  localparam int W     = WINDOW_BITS;
  localparam int SUM_W = ((W > 32) ? W : 32) + 1;
  localparam logic [W-1:0] WMAX = {W{1'b1}};

  // Segment size and protocol state.
  logic [reno_cw_pkg::MSS_W-1:0] mss;
  reno_cw_pkg::phase_t           mode;
  logic [W-1:0]                  cw;
  logic [W-1:0]                  thr;
  logic [reno_cw_pkg::ACK_W-1:0] last_ack;
  logic [2:0]                    dup_count;

  // Captured item and squared segment size.
  logic                              func_q;
  logic [reno_cw_pkg::ACK_W-1:0]     ack_q;
  logic [reno_cw_pkg::PRODUCT_W-1:0] mss_sq;

  // Next values.
  reno_cw_pkg::phase_t           mode_next;
  logic [W-1:0]                  cw_next;
  logic [W-1:0]                  thr_next;
  logic [reno_cw_pkg::ACK_W-1:0] last_ack_next;
  logic [2:0]                    dup_next;
  logic                          rtx_next;

  // Decision and arithmetic signals.
  logic                              is_new;
  logic                              is_dup;
  logic                              below_thr;
  logic                              cw_zero;
  logic [2:0]                        dup_inc;
  logic                              dup_fast;
  logic [W-1:0]                      halved;
  logic [W-1:0]                      half_cw;
  logic [W-1:0]                      mss_w;
  logic [reno_cw_pkg::MSS_W+1:0]     mss3;
  logic [reno_cw_pkg::DIVIDEND_W-1:0] quotient;
  logic [31:0]                       inc;
  logic                              div_done;
  logic [W-1:0]                      add_a;
  logic [31:0]                       add_b;
  logic [SUM_W-1:0]                  sum_full;
  logic [W-1:0]                      sum_sat;

  // Segment-size register; the user must write it only while the engine is idle, as the block itself has no check.
  always_ff @(posedge clk) begin
    if (rst) begin
      mss <= reno_cw_pkg::RESET_MSS;
    end else if (cfg_wr_en) begin
      mss <= cfg_wr_data;
    end
  end

  // Capture the item and square the segment size for a possible divide.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q <= in_func;
      ack_q  <= in_ack;
      mss_sq <= reno_cw_pkg::PRODUCT_W'(mss) * reno_cw_pkg::PRODUCT_W'(mss);
    end
  end

  // Classify the acknowledgment against the last one seen.
  assign is_new    = (last_ack == '0) || (ack_q > last_ack);
  assign is_dup    = !is_new && (ack_q == last_ack);
  assign below_thr = cw < thr;
  assign cw_zero   = (cw == '0);
  assign dup_inc   = (dup_count < reno_cw_pkg::DUP_SAT) ? dup_count + 3'd1 : dup_count;
  assign dup_fast  = is_dup && (mode == reno_cw_pkg::PH_SLOW || mode == reno_cw_pkg::PH_AVOID)
                     && (dup_inc == reno_cw_pkg::DUP_FAST);

  // Threshold after a loss: half the window, but at least one segment.
  assign mss_w   = W'(mss);
  assign half_cw = cw >> 1;
  assign halved  = (half_cw > mss_w) ? half_cw : mss_w;
  assign mss3    = (reno_cw_pkg::MSS_W + 2)'({mss, 1'b0}) + (reno_cw_pkg::MSS_W + 2)'(mss);

  // The avoidance step divides mss*mss by the window.
  assign status.need_div = (func_q == reno_cw_pkg::FUNC_ACK) && is_new && !cw_zero
                           && (mode == reno_cw_pkg::PH_AVOID
                               || (mode == reno_cw_pkg::PH_SLOW && !below_thr));
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

  reno_cw_div #(
    .DIVISOR_W (W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (mss_sq),
    .divisor  (cw),
    .done     (div_done),
    .quotient (quotient)
  );

  assign inc = cw_zero ? 32'd0 : quotient;

  // Operands of the single saturating adder. Slow start below the threshold and a duplicate in recovery add
  // one segment, a new ack otherwise the avoidance increment, fast retransmit three segments to the halved window.
  always_comb begin
    add_a = cw;
    add_b = 32'(mss);
    priority if (dup_fast) begin
      add_a = halved;
      add_b = 32'(mss3);
    end else if (is_new && !(mode == reno_cw_pkg::PH_SLOW && below_thr)) begin
      add_b = inc;
    end else begin
      add_b = 32'(mss);
    end
  end

  assign sum_full = SUM_W'(add_a) + SUM_W'(add_b);
  assign sum_sat  = (sum_full > SUM_W'(WMAX)) ? WMAX : W'(sum_full);

  // Reno state update for one item.
  always_comb begin
    mode_next     = mode;
    cw_next       = cw;
    thr_next      = thr;
    last_ack_next = last_ack;
    dup_next      = dup_count;
    rtx_next      = 1'b0;
    if (func_q == reno_cw_pkg::FUNC_TIMEOUT) begin
      mode_next     = reno_cw_pkg::PH_SLOW;
      thr_next      = halved;
      cw_next       = mss_w;
      last_ack_next = '0;
      dup_next      = '0;
    end else if (is_new) begin
      last_ack_next = ack_q;
      dup_next      = '0;
      unique case (mode)
        reno_cw_pkg::PH_RECOV: begin
          mode_next = reno_cw_pkg::PH_AVOID;
          cw_next   = thr;
        end
        reno_cw_pkg::PH_SLOW: begin
          if (below_thr) begin
            cw_next = sum_sat;
          end else begin
            mode_next = reno_cw_pkg::PH_AVOID;
            cw_next   = sum_sat;
          end
        end
        reno_cw_pkg::PH_AVOID: begin
          cw_next = sum_sat;
        end
        default: begin
          // Unused phase code: the ack leaves everything as it is.
          last_ack_next = last_ack;
          dup_next      = dup_count;
        end
      endcase
    end else if (is_dup) begin
      unique case (mode)
        reno_cw_pkg::PH_RECOV: begin
          cw_next  = sum_sat;
          rtx_next = 1'b1;
        end
        reno_cw_pkg::PH_SLOW, reno_cw_pkg::PH_AVOID: begin
          dup_next = dup_inc;
          if (dup_fast) begin
            mode_next = reno_cw_pkg::PH_RECOV;
            thr_next  = halved;
            cw_next   = sum_sat;
            rtx_next  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Protocol state registers, updated when the result is committed.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= reno_cw_pkg::PH_SLOW;
      cw        <= W'(reno_cw_pkg::RESET_WINDOW);
      thr       <= W'(reno_cw_pkg::RESET_THRESHOLD);
      last_ack  <= '0;
      dup_count <= '0;
    end else if (cmd.commit) begin
      mode      <= mode_next;
      cw        <= cw_next;
      thr       <= thr_next;
      last_ack  <= last_ack_next;
      dup_count <= dup_next;
    end
  end

  // Result register; a waiting result does not block the next capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_retransmit <= rtx_next;
      out_window     <= reno_cw_pkg::OUT_WIN_W'(cw_next);
      out_phase      <= mode_next;
    end
  end

endmodule

FILE: rtl/reno_congestion_window.sv
// Reno congestion-window engine. Each slave transfer carries either an
// acknowledgment number (tuser 0) or a retransmission timeout (tuser 1) and
// yields exactly one master transfer with the new window, the phase and a
// fast-retransmit flag. An accepted item is evaluated and then committed to
// the result register. A new ack in congestion avoidance, or in slow start at
// or above the threshold, first needs the increment mss*mss/window, which the
// radix-2 divider produces one quotient bit per cycle. The next item is taken
// once the last is committed, even while its result still waits in the output
// register, and that item's commit waits until the output register is free.
// The user must write the segment size through cfg_wr_en and cfg_wr_data only
// while the engine is idle; the block itself has no check for it. The window
// is kept at WINDOW_BITS bits, saturating, and its low 32 bits are reported.
module reno_congestion_window #(
  parameter int WINDOW_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Segment-size register write.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] ack_number
  input  logic [0:0]  s_tuser,   // [0] func
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] window, [33:32] phase, [39:34] zero
  output logic [0:0]  m_tuser    // [0] retransmit
);

  reno_cw_pkg::cw_cmd_t    cmd;
  reno_cw_pkg::cw_status_t status;

  logic                                  out_retransmit;
  logic [reno_cw_pkg::OUT_WIN_W-1:0]     out_window;
  reno_cw_pkg::phase_t                   out_phase;

  reno_cw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  reno_cw_dp #(
    .WINDOW_BITS (WINDOW_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_ack         (s_tdata),
    .in_func        (s_tuser[0]),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_retransmit (out_retransmit),
    .out_window     (out_window),
    .out_phase      (out_phase)
  );

  // Pack the result fields, lowest field first.
  assign m_tdata = {6'd0, out_phase, out_window};
  assign m_tuser = out_retransmit;

endmodule
